// ----- design/mqb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqb_pkg
// Shared types and constants of the drop-oldest multi-queue buffer.
// ----------------------------------------------------------------------------
package mqb_pkg;

    // Default sizing of the buffer.
    localparam int NUM_QUEUES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the channels.
    localparam int CMD_W   = 3;
    localparam int QIDX_W  = 3;
    localparam int WORD_W  = 32;
    localparam int CAP_W   = 5;
    localparam int PEND_W  = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GAP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORGET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

    // One result transaction.
    typedef struct packed {
        logic [WORD_W-1:0] event_payload;
        logic              has_event;
        logic [WORD_W-1:0] dropped_count;
        logic              gap_flag;
        logic [PEND_W-1:0] pending_count;
        logic [WORD_W-1:0] dropped_total;
        logic              last;
    } out_item_t;

    // Occupancy report of the output buffer to the controller.
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } ob_status_t;

endpackage

// ----- design/mqb_if.sv -----
// ----------------------------------------------------------------------------
// mqb_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface mqb_in_if;
    logic                        valid;
    logic                        ready;
    logic [mqb_pkg::CMD_W-1:0]   command;
    logic [mqb_pkg::QIDX_W-1:0]  queue_index;
    logic [mqb_pkg::WORD_W-1:0]  payload;

    modport source (output valid, output command, output queue_index, output payload,
                    input ready);
    modport sink   (input valid, input command, input queue_index, input payload,
                    output ready);
endinterface

interface mqb_out_if;
    logic                        valid;
    logic                        ready;
    logic [mqb_pkg::WORD_W-1:0]  event_payload;
    logic                        has_event;
    logic [mqb_pkg::WORD_W-1:0]  dropped_count;
    logic                        gap_flag;
    logic [mqb_pkg::PEND_W-1:0]  pending_count;
    logic [mqb_pkg::WORD_W-1:0]  dropped_total;
    logic                        last;

    modport source (output valid, output event_payload, output has_event,
                    output dropped_count, output gap_flag, output pending_count,
                    output dropped_total, output last, input ready);
    modport sink   (input valid, input event_payload, input has_event,
                    input dropped_count, input gap_flag, input pending_count,
                    input dropped_total, input last, output ready);
endinterface

// ----- design/drop_oldest_multi_queue_buffer.sv -----
// Push and mark gap read the queue metadata and write it back in the next state; forget,
// clear and unknown commands take effect in the accepting state. Query and take start their
// results after the metadata memory read; take then gives one result per cycle while the
// output buffer has room, and holds the command port until its last result has started.
// Reset clears the per-queue valid bits, the total and the capacity (to 16) at once;
// the entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// drop_oldest_multi_queue_buffer
// Bounded event queues that evict their oldest entry when a push finds them full.
// ----------------------------------------------------------------------------
module drop_oldest_multi_queue_buffer #(
    parameter int NUM_QUEUES   = mqb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = mqb_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mqb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mqb_in_if.sink                      cmd_ch,
    mqb_out_if.source                   res_ch,
    input  logic                        cfg_we,
    input  logic [mqb_pkg::CAP_W-1:0]   cfg_wdata
);

    // The capacity register is shared by every queue. Zero acts as one and
    // values above the queue depth act as the depth; the controller applies
    // both rules when it evaluates a push.
    logic [mqb_pkg::CAP_W-1:0] cap_reg, cap_next;

    // Each result transaction leaves the controller through a one-entry stage
    // and lands in a two-entry output buffer. The controller only starts a
    // result when the buffer is sure to have room, so a stalled consumer
    // never causes a result to be lost.
    logic                      res_push;
    mqb_pkg::out_item_t        res_item;
    mqb_pkg::ob_status_t       ob_status;

    assign cap_next = cfg_we ? cfg_wdata : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= mqb_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // The controller holds the queue metadata (head, fill, dropped count and
    // gap flag) in one memory and the event words in another. Every command
    // that needs metadata reads it in the cycle it is accepted; push and mark
    // gap modify and write it back in the next one. Commands are taken one at a time,
    // so a read never overlaps a pending write to the same queue.
    mqb_ctrl #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .capacity  (cap_reg),
        .res_push  (res_push),
        .res_item  (res_item),
        .ob_status (ob_status)
    );

    mqb_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .res_ch    (res_ch),
        .status    (ob_status)
    );

endmodule

// ----- design/mqb_ram.sv -----
// ----------------------------------------------------------------------------
// mqb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mqb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/mqb_outbuf.sv -----
// ----------------------------------------------------------------------------
// mqb_outbuf
// Two-entry result buffer that decouples the controller from the consumer.
// ----------------------------------------------------------------------------
module mqb_outbuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mqb_pkg::out_item_t     push_item,
    mqb_out_if.source              res_ch,
    output mqb_pkg::ob_status_t    status
);

    mqb_pkg::out_item_t slot_reg [2];
    logic               wptr_reg, wptr_next;
    logic               rptr_reg, rptr_next;
    logic [1:0]         count_reg, count_next;
    mqb_pkg::out_item_t head;
    logic               pop;

    assign head = slot_reg[rptr_reg];
    assign pop  = res_ch.valid && res_ch.ready;

    assign res_ch.valid         = (count_reg != 2'd0);
    assign res_ch.event_payload = head.event_payload;
    assign res_ch.has_event     = head.has_event;
    assign res_ch.dropped_count = head.dropped_count;
    assign res_ch.gap_flag      = head.gap_flag;
    assign res_ch.pending_count = head.pending_count;
    assign res_ch.dropped_total = head.dropped_total;
    assign res_ch.last          = head.last;

    assign status.count = count_reg;
    assign status.pop   = pop;

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/mqb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mqb_ctrl
// Command sequencer: per-queue metadata memory, entry memory and drain loop.
// ----------------------------------------------------------------------------
module mqb_ctrl #(
    parameter int NUM_QUEUES   = mqb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = mqb_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mqb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mqb_in_if.sink                      cmd_ch,
    input  logic [mqb_pkg::CAP_W-1:0]   capacity,
    output logic                        res_push,
    output mqb_pkg::out_item_t          res_item,
    input  mqb_pkg::ob_status_t         ob_status
);

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int EDEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int EW     = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam int WW     = mqb_pkg::WORD_W;
    localparam int MW     = HW + CW + WW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_META  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // Control registers.
    logic [1:0]             state_reg, state_next;
    logic [NUM_QUEUES-1:0]  mvalid_reg, mvalid_next;
    logic [WW-1:0]          total_reg, total_next;
    logic                   res_valid_reg, res_valid_next;

    // Payload registers.
    logic [mqb_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [QW-1:0]          q_reg, q_next;
    logic                   idx_ok_reg, idx_ok_next;
    logic [EW-1:0]          base_reg, base_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [HW-1:0]          dhead_reg, dhead_next;
    logic [CW-1:0]          remain_reg, remain_next;
    logic [WW-1:0]          tdrop_reg, tdrop_next;
    logic                   tgap_reg, tgap_next;
    logic                   res_ram_reg, res_ram_next;
    mqb_pkg::out_item_t     res_item_reg, res_item_next;

    // Input decode.
    logic                   acc;
    logic [8:0]             qi_ext;
    logic [QW-1:0]          q_in;
    logic                   idx_ok_in;
    logic [63:0]            pay_ext;

    // Memory ports.
    logic                   m_we;
    logic [MW-1:0]          m_wdata;
    logic [MW-1:0]          m_rdata;
    logic                   e_we;
    logic [EW-1:0]          e_waddr;
    logic                   e_re;
    logic [EW-1:0]          e_raddr;
    logic [PAYLOAD_BITS-1:0] e_rdata;
    logic [63:0]            rd_ext;

    // Metadata of the addressed queue.
    logic                   meta_live;
    logic [HW-1:0]          r_head, m_head;
    logic [CW-1:0]          r_count, m_count;
    logic [WW-1:0]          r_drop, m_drop;
    logic                   r_gap, m_gap;

    // Push arithmetic.
    logic [CW-1:0]          cap1;
    logic [CW-1:0]          eff_cap;
    logic                   evict;
    logic [CW-1:0]          n_ev;
    logic [11:0]            hsum;
    logic [HW-1:0]          head1;
    logic [CW-1:0]          count1;
    logic [11:0]            ssum;
    logic [HW-1:0]          slot;
    logic [WW:0]            dsum;
    logic [WW:0]            tsum;
    logic [WW-1:0]          p_drop;
    logic [WW-1:0]          p_total;

    logic [2:0]             credit_used;
    logic                   issue_ok;

    assign acc          = cmd_ch.valid && cmd_ch.ready;
    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign qi_ext       = 9'(cmd_ch.queue_index);
    assign q_in         = qi_ext[QW-1:0];
    assign idx_ok_in    = (qi_ext < 9'(NUM_QUEUES));
    assign pay_ext      = 64'(cmd_ch.payload);

    mqb_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_QUEUES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (q_reg),
        .wdata (m_wdata),
        .re    (acc),
        .raddr (q_in),
        .rdata (m_rdata)
    );

    mqb_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (EDEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (pay_reg),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // A queue whose valid bit is clear reads as empty and unused.
    always_comb
    begin
        {r_head, r_count, r_drop, r_gap} = m_rdata;
        meta_live = idx_ok_reg && mvalid_reg[q_reg];
        m_head    = meta_live ? r_head : '0;
        m_count   = meta_live ? r_count : '0;
        m_drop    = meta_live ? r_drop : '0;
        m_gap     = meta_live ? r_gap : 1'b0;
    end

    always_comb
    begin
        cap1    = (capacity == '0) ? CW'(1) : CW'(capacity);
        eff_cap = (11'(capacity) > 11'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) :
                  ((capacity == '0) ? CW'(1) : cap1);
        evict   = (m_count >= eff_cap);
        n_ev    = evict ? (m_count - eff_cap + CW'(1)) : '0;
        hsum    = 12'(m_head) + 12'(n_ev);
        head1   = (hsum >= 12'(QUEUE_DEPTH)) ? HW'(hsum - 12'(QUEUE_DEPTH)) : HW'(hsum);
        count1  = m_count - n_ev;
        ssum    = 12'(head1) + 12'(count1);
        slot    = (ssum >= 12'(QUEUE_DEPTH)) ? HW'(ssum - 12'(QUEUE_DEPTH)) : HW'(ssum);
        dsum    = {1'b0, m_drop} + (WW + 1)'(n_ev);
        tsum    = {1'b0, total_reg} + (WW + 1)'(n_ev);
        p_drop  = dsum[WW] ? '1 : dsum[WW-1:0];
        p_total = tsum[WW] ? '1 : tsum[WW-1:0];
    end

    // A result may start only when the buffer still has room for it once the
    // result already in flight has landed.
    assign credit_used = 3'(ob_status.count) + 3'(res_valid_reg);
    assign issue_ok    = credit_used < (ob_status.pop ? 3'd3 : 3'd2);

    assign e_waddr = base_reg + EW'(slot);
    assign e_raddr = base_reg + EW'(dhead_reg);

    always_comb
    begin
        state_next     = state_reg;
        mvalid_next    = mvalid_reg;
        total_next     = total_reg;
        res_valid_next = 1'b0;
        res_ram_next   = 1'b0;
        res_item_next  = res_item_reg;
        dhead_next     = dhead_reg;
        remain_next    = remain_reg;
        tdrop_next     = tdrop_reg;
        tgap_next      = tgap_reg;
        m_we           = 1'b0;
        m_wdata        = {head1, count1 + CW'(1), p_drop, 1'b1};
        e_we           = 1'b0;
        e_re           = 1'b0;

        cmd_next    = acc ? cmd_ch.command : cmd_reg;
        q_next      = acc ? q_in : q_reg;
        idx_ok_next = acc ? idx_ok_in : idx_ok_reg;
        base_next   = acc ? EW'(32'(q_in) * 32'(QUEUE_DEPTH)) : base_reg;
        pay_next    = acc ? pay_ext[PAYLOAD_BITS-1:0] : pay_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cmd_ch.command inside {mqb_pkg::CMD_PUSH, mqb_pkg::CMD_GAP,
                                               mqb_pkg::CMD_TAKE, mqb_pkg::CMD_QUERY})
                    begin
                        state_next = S_META;
                    end
                    else if (cmd_ch.command == mqb_pkg::CMD_FORGET)
                    begin
                        if (idx_ok_in)
                        begin
                            mvalid_next[q_in] = 1'b0;
                        end
                    end
                    else if (cmd_ch.command == mqb_pkg::CMD_CLEAR)
                    begin
                        mvalid_next = '0;
                    end
                end
            end

            S_META:
            begin
                state_next = S_IDLE;
                case (cmd_reg)
                    mqb_pkg::CMD_PUSH:
                    begin
                        if (idx_ok_reg)
                        begin
                            e_we               = 1'b1;
                            m_we               = 1'b1;
                            m_wdata            = {head1, count1 + CW'(1), p_drop,
                                                  m_gap | evict};
                            mvalid_next[q_reg] = 1'b1;
                            total_next         = p_total;
                        end
                    end
                    mqb_pkg::CMD_GAP:
                    begin
                        if (idx_ok_reg)
                        begin
                            m_we               = 1'b1;
                            m_wdata            = {m_head, m_count, m_drop, 1'b1};
                            mvalid_next[q_reg] = 1'b1;
                        end
                    end
                    mqb_pkg::CMD_TAKE:
                    begin
                        dhead_next  = m_head;
                        remain_next = m_count;
                        tdrop_next  = m_drop;
                        tgap_next   = m_gap;
                        if (idx_ok_reg)
                        begin
                            mvalid_next[q_reg] = 1'b0;
                        end
                        state_next = S_DRAIN;
                    end
                    mqb_pkg::CMD_QUERY:
                    begin
                        if (issue_ok)
                        begin
                            res_valid_next = 1'b1;
                            res_item_next  = '{event_payload: '0,
                                               has_event:     1'b0,
                                               dropped_count: m_drop,
                                               gap_flag:      m_gap,
                                               pending_count: mqb_pkg::PEND_W'(m_count),
                                               dropped_total: total_reg,
                                               last:          1'b1};
                        end
                        else
                        begin
                            state_next = S_META;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DRAIN:
            begin
                if (issue_ok)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{event_payload: '0,
                                       has_event:     1'b0,
                                       dropped_count: tdrop_reg,
                                       gap_flag:      tgap_reg,
                                       pending_count: '0,
                                       dropped_total: total_reg,
                                       last:          (remain_reg <= CW'(1))};
                    if (remain_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_re         = 1'b1;
                        res_ram_next = 1'b1;
                        dhead_next   = (dhead_reg == HW'(QUEUE_DEPTH - 1)) ? '0 :
                                       dhead_reg + HW'(1);
                        remain_next  = remain_reg - CW'(1);
                        if (remain_reg == CW'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_ext   = 64'(e_rdata);
    assign res_push = res_valid_reg;

    always_comb
    begin
        res_item               = res_item_reg;
        res_item.event_payload = res_ram_reg ? rd_ext[WW-1:0] : '0;
        res_item.has_event     = res_ram_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mvalid_reg    <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mvalid_reg    <= mvalid_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        q_reg        <= q_next;
        idx_ok_reg   <= idx_ok_next;
        base_reg     <= base_next;
        pay_reg      <= pay_next;
        dhead_reg    <= dhead_next;
        remain_reg   <= remain_next;
        tdrop_reg    <= tdrop_next;
        tgap_reg     <= tgap_next;
        res_ram_reg  <= res_ram_next;
        res_item_reg <= res_item_next;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the drop-oldest multi-queue buffer. A shadow copy
// of every queue predicts the results of each accepted command. The monitor
// compares each result transaction, field by field, against the oldest
// prediction. The capacity register is swept between phases while the buffer
// is idle. Both handshakes idle at random, and one long receiver hold-off
// backs the buffer up into its command port.
// ----------------------------------------------------------------------------
module testbench;

    // Local names for the shared constants and types of the buffer.
    localparam int CMD_W           = mqb_pkg::CMD_W;
    localparam int QIDX_W          = mqb_pkg::QIDX_W;
    localparam int WORD_W          = mqb_pkg::WORD_W;
    localparam int CAP_W           = mqb_pkg::CAP_W;
    localparam int PEND_W          = mqb_pkg::PEND_W;
    localparam int NUM_QUEUES_DEF  = mqb_pkg::NUM_QUEUES_DEF;
    localparam int QUEUE_DEPTH_DEF = mqb_pkg::QUEUE_DEPTH_DEF;
    localparam logic [CAP_W-1:0] CAP_RESET  = mqb_pkg::CAP_RESET;
    localparam logic [CMD_W-1:0] CMD_PUSH   = mqb_pkg::CMD_PUSH;
    localparam logic [CMD_W-1:0] CMD_GAP    = mqb_pkg::CMD_GAP;
    localparam logic [CMD_W-1:0] CMD_TAKE   = mqb_pkg::CMD_TAKE;
    localparam logic [CMD_W-1:0] CMD_FORGET = mqb_pkg::CMD_FORGET;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = mqb_pkg::CMD_CLEAR;
    localparam logic [CMD_W-1:0] CMD_QUERY  = mqb_pkg::CMD_QUERY;
    typedef mqb_pkg::out_item_t out_item_t;

    // The command field is three bits wide, but only six codes are defined.
    // The two spare codes must be swallowed without any effect.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Random items per capacity phase, and the number of capacity phases.
    localparam int PHASE_ITEMS = 45;
    localparam int NUM_PHASES  = 8;

    // ------------------------------------------------------------------------
    // Shadow of the buffer. It keeps each queue as a plain queue of words,
    // together with the drop counters and gap flags, and turns each accepted
    // command into the result transactions that the buffer must produce.
    // ------------------------------------------------------------------------
    class buffer_shadow;
        logic [WORD_W-1:0] held [NUM_QUEUES_DEF][$];
        logic [WORD_W-1:0] drops [NUM_QUEUES_DEF];
        logic              gaps [NUM_QUEUES_DEF];
        logic [WORD_W-1:0] total;
        logic [CAP_W-1:0]  capacity;
        out_item_t         awaited_results [$];
        int                mismatches;

        function new();
            for (int q = 0; q < NUM_QUEUES_DEF; q++)
                forget_queue(q);
            total      = '0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void forget_queue(int q);
            held[q].delete();
            drops[q] = '0;
            gaps[q]  = 1'b0;
        endfunction

        // Zero counts as one, anything above the depth as the full depth.
        function int unsigned limit();
            int unsigned c;
            c = 32'(capacity);
            if (c == 0)
                c = 1;
            if (c > QUEUE_DEPTH_DEF)
                c = QUEUE_DEPTH_DEF;
            return c;
        endfunction

        function logic [WORD_W-1:0] saturate(logic [WORD_W-1:0] a, int unsigned n);
            logic [WORD_W:0] s;
            s = {1'b0, a} + 33'(n);
            return s[WORD_W] ? '1 : s[WORD_W-1:0];
        endfunction

        function void expect_result(logic [WORD_W-1:0] pay, logic has,
                                    logic [WORD_W-1:0] drop, logic gap,
                                    logic [PEND_W-1:0] pend, logic fin);
            out_item_t r;
            r.event_payload = pay;
            r.has_event     = has;
            r.dropped_count = drop;
            r.gap_flag      = gap;
            r.pending_count = pend;
            r.dropped_total = total;
            r.last          = fin;
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        // Every queue index that three bits can carry addresses a real queue,
        // so the out-of-range handling never comes into play here.
        function void note_command(logic [CMD_W-1:0] cmd, logic [QIDX_W-1:0] qi,
                                   logic [WORD_W-1:0] pay);
            int unsigned cap;
            int unsigned evict;
            int unsigned n;
            cap = limit();
            case (cmd)
                CMD_PUSH:
                begin
                    if (held[qi].size() >= cap)
                    begin
                        evict = held[qi].size() - cap + 1;
                        repeat (evict) held[qi].delete(0);
                        drops[qi] = saturate(drops[qi], evict);
                        total     = saturate(total, evict);
                        gaps[qi]  = 1'b1;
                    end
                    held[qi].insert(held[qi].size(), pay);
                end
                CMD_GAP:
                begin
                    gaps[qi] = 1'b1;
                end
                CMD_TAKE:
                begin
                    n = held[qi].size();
                    if (n == 0)
                        expect_result('0, 1'b0, drops[qi], gaps[qi], '0, 1'b1);
                    else
                        for (int i = 0; i < n; i++)
                            expect_result(held[qi][i], 1'b1, drops[qi], gaps[qi], '0,
                                          i == n - 1);
                    forget_queue(qi);
                end
                CMD_FORGET:
                begin
                    forget_queue(qi);
                end
                CMD_CLEAR:
                begin
                    for (int q = 0; q < NUM_QUEUES_DEF; q++)
                        forget_queue(q);
                end
                CMD_QUERY:
                begin
                    expect_result('0, 1'b0, drops[qi], gaps[qi],
                                  PEND_W'(held[qi].size()), 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result transaction with no prediction waiting: payload 0x%08h",
                       got.event_payload);
                mismatches++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            compare_field("event_payload", want.event_payload, got.event_payload);
            compare_field("has_event", WORD_W'(want.has_event), WORD_W'(got.has_event));
            compare_field("dropped_count", want.dropped_count, got.dropped_count);
            compare_field("gap_flag", WORD_W'(want.gap_flag), WORD_W'(got.gap_flag));
            compare_field("pending_count", WORD_W'(want.pending_count),
                          WORD_W'(got.pending_count));
            compare_field("dropped_total", want.dropped_total, got.dropped_total);
            compare_field("last", WORD_W'(want.last), WORD_W'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    mqb_in_if  cmd_ch ();
    mqb_out_if res_ch ();

    drop_oldest_multi_queue_buffer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    buffer_shadow shadow = new();

    // Sender pacing: when gaps are on, the sender offers bursts of random
    // length and drops valid between them.
    bit sender_gaps;
    int burst_left;

    // Receiver pacing: a stall style per phase, plus a long hold-off that the
    // stimulus can request and that the receiver counts down on its own.
    int sink_style;
    int sink_tick;
    int hold_left;

    // Two queues per phase get most of the traffic, so that they fill up
    // and overflow instead of being spread thin across all eight.
    logic [QIDX_W-1:0] hot_queue [2];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous limit: even with every item draining a full queue through the
    // slowest stall pattern, the run ends far below this.
    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver. Outputs are sampled at the rising edge, so
    // they hold the values from before the edge; ready for the next cycle is
    // chosen in the same step with a nonblocking assignment.
    // ------------------------------------------------------------------------
    initial
    begin
        out_item_t got;
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.event_payload = res_ch.event_payload;
                got.has_event     = res_ch.has_event;
                got.dropped_count = res_ch.dropped_count;
                got.gap_flag      = res_ch.gap_flag;
                got.pending_count = res_ch.pending_count;
                got.dropped_total = res_ch.dropped_total;
                got.last          = res_ch.last;
                shadow.check_result(got);
            end
            if (hold_left > 0)
            begin
                // The long hold-off lets the buffer back up all the way to the
                // command port while the sender keeps offering.
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (sink_style)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:
                    begin
                        res_ch.ready <= (sink_tick % 5) < 3;
                        sink_tick++;
                    end
                    default: res_ch.ready <= ($urandom_range(0, 9) < 4);
                endcase
            end
        end
    end

    // Offers one command and waits until the transaction is accepted. The
    // shadow is told at the accepting edge, so predictions keep the same
    // order as the buffer sees the commands.
    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [QIDX_W-1:0] qi,
                                 input logic [WORD_W-1:0] pay);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.queue_index <= qi;
        cmd_ch.payload     <= pay;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        shadow.note_command(cmd, qi, pay);
        // Valid stays high across a burst; it is only lowered for a gap, and
        // never lowered and raised again within one step.
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Stops offering, waits for every predicted result, and then lets the
    // buffer finish commands that produce no result, since a push can still
    // be writing back its metadata.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (shadow.awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Capacity writes happen only while the buffer is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow.capacity = value;
    endtask

    // One random command. Pushes dominate so that queues fill and evict; the
    // rest mixes drains, queries, gap marks, resets and the spare codes.
    task automatic random_command();
        int unsigned roll;
        logic [CMD_W-1:0] cmd;
        logic [QIDX_W-1:0] qi;
        logic [WORD_W-1:0] pay;
        roll = $urandom_range(0, 99);
        if (roll < 56)
            cmd = CMD_PUSH;
        else if (roll < 67)
            cmd = CMD_TAKE;
        else if (roll < 78)
            cmd = CMD_QUERY;
        else if (roll < 85)
            cmd = CMD_GAP;
        else if (roll < 91)
            cmd = CMD_FORGET;
        else if (roll < 94)
            cmd = CMD_CLEAR;
        else if (roll < 97)
            cmd = CMD_SPARE_LO;
        else
            cmd = CMD_SPARE_HI;
        if ($urandom_range(0, 99) < 70)
            qi = hot_queue[$urandom_range(0, 1)];
        else
            qi = QIDX_W'($urandom_range(0, NUM_QUEUES_DEF - 1));
        roll = $urandom_range(0, 19);
        if (roll == 0)
            pay = '0;
        else if (roll == 1)
            pay = '1;
        else
            pay = $urandom;
        offer_command(cmd, qi, pay);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, a directed part that walks each command and corner
    // case, then random phases across a sweep of capacities.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CAP_W-1:0] phase_caps [NUM_PHASES];

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_PUSH;
        cmd_ch.queue_index <= '0;
        cmd_ch.payload     <= '0;
        sender_gaps = 1'b0;
        burst_left  = 0;
        sink_style  = 1;
        sink_tick   = 0;
        hold_left   = 0;

        // The list mixes the reset value, both ends of the register, values
        // above the depth and a few middle values; queue fill carries over
        // from one phase to the next, so lowering the capacity also forces
        // multi-entry evictions.
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd3, 5'd31, 5'd5, 5'd20,
                       5'($urandom_range(0, 31))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drain and query of queues that were never used after reset.
        offer_command(CMD_TAKE, 3'd0, '0);
        offer_command(CMD_QUERY, 3'd7, '1);
        // Extreme payloads and extreme queue indexes.
        offer_command(CMD_PUSH, 3'd0, 32'h0000_0000);
        offer_command(CMD_PUSH, 3'd0, 32'hFFFF_FFFF);
        offer_command(CMD_PUSH, 3'd7, 32'hA5A5_A5A5);
        // A gap mark on an empty queue shows up in query and in take.
        offer_command(CMD_GAP, 3'd3, '0);
        offer_command(CMD_QUERY, 3'd3, '0);
        offer_command(CMD_QUERY, 3'd0, '0);
        offer_command(CMD_TAKE, 3'd0, '0);
        offer_command(CMD_TAKE, 3'd3, '0);
        // Spare command codes change nothing.
        offer_command(CMD_SPARE_LO, 3'd1, 32'hFFFF_FFFF);
        offer_command(CMD_SPARE_HI, 3'd2, 32'h5A5A_5A5A);
        // Forget throws away the held entry of queue seven.
        offer_command(CMD_FORGET, 3'd7, '0);
        offer_command(CMD_QUERY, 3'd7, '0);
        // Clear empties every queue at once.
        offer_command(CMD_PUSH, 3'd2, 32'h1234_5678);
        offer_command(CMD_PUSH, 3'd5, 32'h8765_4321);
        offer_command(CMD_CLEAR, 3'd0, '0);
        offer_command(CMD_TAKE, 3'd2, '0);

        // Capacity zero behaves as one: each push after the first evicts.
        write_capacity(5'd0);
        for (int i = 0; i < 3; i++)
            offer_command(CMD_PUSH, 3'd4, 32'hC000_0000 + i);
        offer_command(CMD_QUERY, 3'd4, '0);
        offer_command(CMD_TAKE, 3'd4, '0);

        // Lowering the capacity below a queue's fill makes the next push
        // evict several entries in one go.
        write_capacity(5'd4);
        for (int i = 0; i < 4; i++)
            offer_command(CMD_PUSH, 3'd6, 32'hD000_0000 + i);
        write_capacity(5'd1);
        offer_command(CMD_PUSH, 3'd6, 32'hDEAD_BEEF);
        offer_command(CMD_QUERY, 3'd6, '0);
        offer_command(CMD_TAKE, 3'd6, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_capacity(phase_caps[ph]);
            hot_queue[0] = QIDX_W'($urandom_range(0, NUM_QUEUES_DEF - 1));
            hot_queue[1] = QIDX_W'($urandom_range(0, NUM_QUEUES_DEF - 1));
            sink_style  = ph % 4;
            sender_gaps = (ph % 3) != 0;
            burst_left  = $urandom_range(1, 12);
            // In one phase the receiver stops for a long stretch while the
            // sender keeps offering, so the buffer fills and stalls its input.
            if (ph == 3)
                hold_left = 150;
            repeat (PHASE_ITEMS) random_command();
        end

        settle();
        repeat (30) @(posedge clk);

        if (shadow.awaited_results.size() != 0)
        begin
            $error("%0d predicted result transactions never arrived",
                   shadow.awaited_results.size());
            shadow.mismatches++;
        end

        if (shadow.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
